// ----- hw/rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, sizes and helpers of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // pool geometry
    localparam int NUM_ORDERS      = 16;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int ADDR_W          = NUM_ORDERS - 1;
    localparam int POOL_BYTES      = 1 << ADDR_W;
    localparam int MAP_BITS        = POOL_BYTES >> 2;
    localparam int NODE_W          = $clog2(MAP_BITS);
    localparam int WORD_W          = (MAP_BITS < 64) ? MAP_BITS : 64;
    localparam int BIT_W           = $clog2(WORD_W);
    localparam int MAP_WORDS       = MAP_BITS / WORD_W;
    localparam int WA_W            = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int ORD_W           = $clog2(NUM_ORDERS);
    localparam int CNT_W           = NODE_W;
    localparam int MIN_W           = $clog2(MIN_BLOCK_BYTES);

    // item field widths
    localparam int CMD_W  = 2;
    localparam int SIZE_W = 16;
    localparam int STAT_W = 2;
    localparam int KC_W   = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DONATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_BIG  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISALIGN = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RD,
        S_MOD,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_ALLOC_CLR,
        OP_SPLIT_SET,
        OP_MERGE,
        OP_SET
    } op_t;

    // least order whose block holds the raised and rounded size
    function automatic logic [KC_W-1:0] order_for(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0]   r;
        logic [SIZE_W:0]   rm1;
        logic [KC_W-1:0]   k;
        r = (size < SIZE_W'(MIN_BLOCK_BYTES)) ? (SIZE_W+1)'(MIN_BLOCK_BYTES)
                                               : {1'b0, size};
        r = (r + (SIZE_W+1)'(7)) & ~(SIZE_W+1)'(7);
        rm1 = r - (SIZE_W+1)'(1);
        k = '0;
        for (int i = 0; i <= SIZE_W; i++)
        begin
            if (rm1[i])
            begin
                k = KC_W'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

// ----- hw/rtl/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/buddy_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator; free blocks kept as heap-indexed bitmap words in RAM.
// ----------------------------------------------------------------------------
// sequence: alloc decodes, scans bitmap words, then does one read-modify-write of a
//   bitmap word per update (split levels + 1); free does one per merge level and a final
//   set; donate a single set; no free block, errors and unused commands skip to the result
// items: one item at a time; the bitmap word read-modify-write sets the pace, and the
//   longest scan reads 32 words (the smallest order, no split)
// reset: all orders empty; per-word valid bits make unwritten words read as zero
// ----------------------------------------------------------------------------
module buddy_block_allocator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  logic [bba_pkg::CMD_W-1:0]        command,
    input  logic [bba_pkg::SIZE_W-1:0]       size_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]       block_address,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [bba_pkg::STAT_W-1:0]       status,
    output logic [bba_pkg::ADDR_W-1:0]       granted_address
);

    bba_pkg::state_t state_reg, state_next;
    bba_pkg::op_t    op_reg, op_next;

    logic [bba_pkg::CMD_W-1:0]  cmd_reg;
    logic [bba_pkg::SIZE_W-1:0] size_reg;
    logic [bba_pkg::ADDR_W-1:0] baddr_reg;

    logic [bba_pkg::ORD_W-1:0]  k_reg, k_next;
    logic [bba_pkg::ORD_W-1:0]  ord_reg, ord_next;
    logic [bba_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [bba_pkg::ADDR_W-1:0] tgt_reg, tgt_next;

    logic [bba_pkg::WA_W:0]     scan_addr_reg, scan_addr_next;
    logic [bba_pkg::WA_W:0]     scan_last_reg, scan_last_next;
    logic                       pend_reg, pend_next;
    logic [bba_pkg::WA_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [bba_pkg::NODE_W-1:0] scan_base_reg, scan_base_next;
    logic [bba_pkg::WORD_W-1:0] scan_mask_reg, scan_mask_next;

    logic [bba_pkg::STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [bba_pkg::ADDR_W-1:0] res_grant_reg, res_grant_next;

    logic                       rsp_valid_reg, rsp_valid_next;
    logic [bba_pkg::STAT_W-1:0] status_reg, status_next;
    logic [bba_pkg::ADDR_W-1:0] grant_reg, grant_next;

    logic [bba_pkg::CNT_W-1:0]  cnt_reg  [bba_pkg::NUM_ORDERS];
    logic [bba_pkg::CNT_W-1:0]  cnt_next [bba_pkg::NUM_ORDERS];
    logic [bba_pkg::MAP_WORDS-1:0] wvalid_reg, wvalid_next;
    logic                       rd_vld_reg;

    // ram ports
    logic                       ram_we, ram_re;
    logic [bba_pkg::WA_W-1:0]   ram_waddr, ram_raddr;
    logic [bba_pkg::WORD_W-1:0] ram_wdata, ram_rdata, rdata_eff;

    // decode terms
    logic [bba_pkg::KC_W-1:0]   k_calc;
    logic                       too_big;
    logic [bba_pkg::ORD_W-1:0]  k4;
    logic [bba_pkg::ADDR_W:0]   bsz;
    logic                       misalign;
    logic                       avail_any;
    logic [bba_pkg::ORD_W-1:0]  avail_j;
    logic                       k_can_merge;
    logic [bba_pkg::ADDR_W:0]   b_full;
    logic [bba_pkg::NODE_W-1:0] b_node;

    // scan terms
    logic                       scan_issue;
    logic [bba_pkg::WORD_W-1:0] hit_bits;
    logic                       hit;
    logic [bba_pkg::BIT_W-1:0]  hit_idx;
    logic [bba_pkg::NODE_W-1:0] hit_node;
    logic [bba_pkg::ADDR_W-1:0] hit_addr;

    // target node of the bitmap update
    logic [bba_pkg::ADDR_W:0]   node_full;
    logic [bba_pkg::NODE_W-1:0] node;
    logic [bba_pkg::WA_W-1:0]   node_word;
    logic [bba_pkg::BIT_W-1:0]  node_bit;
    logic                       cur_bit;
    logic [bba_pkg::ORD_W:0]    ord_up;
    logic [bba_pkg::ADDR_W-1:0] ord_sz, ord_sz_dn, ord_sz_up, merged;
    logic                       res_take;

    // bitmap store
    bba_ram #(
        .WIDTH(bba_pkg::WORD_W),
        .DEPTH(bba_pkg::MAP_WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rdata_eff = rd_vld_reg ? ram_rdata : '0;

    // ---- decode of the captured item
    always_comb
    begin
        k_calc   = bba_pkg::order_for(size_reg);
        too_big  = (k_calc >= bba_pkg::KC_W'(bba_pkg::NUM_ORDERS));
        k4       = k_calc[bba_pkg::ORD_W-1:0];
        bsz      = (bba_pkg::ADDR_W+1)'(1) << k4;
        misalign = (({1'b0, baddr_reg} & (bsz - (bba_pkg::ADDR_W+1)'(1))) != '0)
                || (({1'b0, baddr_reg} + bsz) > (bba_pkg::ADDR_W+1)'(bba_pkg::POOL_BYTES));
        k_can_merge = ({1'b0, k4} + (bba_pkg::ORD_W+1)'(1))
                    < (bba_pkg::ORD_W+1)'(bba_pkg::NUM_ORDERS);
    end

    // lowest order at or above k with a free block
    always_comb
    begin
        avail_any = 1'b0;
        avail_j   = '0;
        for (int i = bba_pkg::NUM_ORDERS - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0 && bba_pkg::ORD_W'(i) >= k4)
            begin
                avail_any = 1'b1;
                avail_j   = bba_pkg::ORD_W'(i);
            end
        end
        b_full = (bba_pkg::ADDR_W+1)'(bba_pkg::POOL_BYTES) >> avail_j;
        b_node = b_full[bba_pkg::NODE_W-1:0];
    end

    // scan hit and first free bit
    always_comb
    begin
        scan_issue = (scan_addr_reg <= scan_last_reg);
        hit_bits   = rdata_eff & scan_mask_reg;
        hit        = pend_reg && (hit_bits != '0);
        hit_idx    = '0;
        for (int i = bba_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (hit_bits[i])
            begin
                hit_idx = bba_pkg::BIT_W'(i);
            end
        end
        hit_node = bba_pkg::NODE_W'({pend_addr_reg, hit_idx});
        hit_addr = bba_pkg::ADDR_W'(hit_node - scan_base_reg) << ord_reg;
    end

    // node of the update target
    always_comb
    begin
        node_full = ((bba_pkg::ADDR_W+1)'(bba_pkg::POOL_BYTES) >> ord_reg)
                  + ({1'b0, tgt_reg} >> ord_reg);
        node      = node_full[bba_pkg::NODE_W-1:0];
        node_word = bba_pkg::WA_W'(node >> bba_pkg::BIT_W);
        node_bit  = node[bba_pkg::BIT_W-1:0];
        cur_bit   = rdata_eff[node_bit];
        ord_up    = {1'b0, ord_reg} + (bba_pkg::ORD_W+1)'(1);
        ord_sz    = bba_pkg::ADDR_W'(1) << ord_reg;
        ord_sz_dn = bba_pkg::ADDR_W'(1) << (ord_reg - bba_pkg::ORD_W'(1));
        ord_sz_up = bba_pkg::ADDR_W'(1) << ord_up[bba_pkg::ORD_W-1:0];
        merged    = addr_reg & ~ord_sz;
        res_take  = !rsp_valid_reg || rsp_ready;
    end

    // ---- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = bba_pkg::S_DECODE;
                end
            end
            bba_pkg::S_DECODE:
            begin
                if (cmd_reg == bba_pkg::CMD_NONE || too_big)
                begin
                    state_next = bba_pkg::S_DONE;
                end
                else if (cmd_reg == bba_pkg::CMD_ALLOC)
                begin
                    state_next = avail_any ? bba_pkg::S_SCAN : bba_pkg::S_DONE;
                end
                else
                begin
                    state_next = misalign ? bba_pkg::S_DONE : bba_pkg::S_RD;
                end
            end
            bba_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = bba_pkg::S_RD;
                end
                else if (!pend_reg && !scan_issue)
                begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_RD:
            begin
                state_next = bba_pkg::S_MOD;
            end
            bba_pkg::S_MOD:
            begin
                case (op_reg)
                    bba_pkg::OP_ALLOC_CLR,
                    bba_pkg::OP_SPLIT_SET:
                        state_next = (ord_reg > k_reg) ? bba_pkg::S_RD : bba_pkg::S_DONE;
                    bba_pkg::OP_MERGE:
                        state_next = bba_pkg::S_RD;
                    default:
                        state_next = bba_pkg::S_DONE;
                endcase
            end
            bba_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // ---- datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        k_next         = k_reg;
        ord_next       = ord_reg;
        addr_next      = addr_reg;
        tgt_next       = tgt_reg;
        scan_addr_next = scan_addr_reg;
        scan_last_next = scan_last_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        scan_base_next = scan_base_reg;
        scan_mask_next = scan_mask_reg;
        res_stat_next  = res_stat_reg;
        res_grant_next = res_grant_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        grant_next     = grant_reg;
        wvalid_next    = wvalid_reg;
        for (int i = 0; i < bba_pkg::NUM_ORDERS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        ram_we    = 1'b0;
        ram_waddr = node_word;
        ram_wdata = rdata_eff;
        ram_re    = 1'b0;
        ram_raddr = node_word;

        case (state_reg)
            bba_pkg::S_DECODE:
            begin
                res_stat_next  = bba_pkg::STAT_OK;
                res_grant_next = '0;
                k_next         = k4;
                if (cmd_reg == bba_pkg::CMD_NONE)
                begin
                    res_stat_next = bba_pkg::STAT_OK;
                end
                else if (too_big)
                begin
                    res_stat_next = bba_pkg::STAT_TOO_BIG;
                end
                else if (cmd_reg == bba_pkg::CMD_ALLOC)
                begin
                    res_stat_next  = bba_pkg::STAT_NO_FREE;
                    ord_next       = avail_j;
                    scan_base_next = b_node;
                    if (b_node >= bba_pkg::NODE_W'(bba_pkg::WORD_W))
                    begin
                        scan_addr_next = (bba_pkg::WA_W+1)'(b_node >> bba_pkg::BIT_W);
                        scan_last_next = (bba_pkg::WA_W+1)'((b_node >> bba_pkg::BIT_W)
                                       + (b_node >> bba_pkg::BIT_W) - bba_pkg::NODE_W'(1));
                        scan_mask_next = '1;
                    end
                    else
                    begin
                        scan_addr_next = '0;
                        scan_last_next = '0;
                        scan_mask_next = ({bba_pkg::WORD_W{1'b1}} << b_node)
                                       ^ ({bba_pkg::WORD_W{1'b1}} << {b_node, 1'b0});
                    end
                end
                else if (misalign)
                begin
                    res_stat_next = bba_pkg::STAT_MISALIGN;
                end
                else
                begin
                    ord_next  = k4;
                    addr_next = baddr_reg;
                    if (cmd_reg == bba_pkg::CMD_FREE && k_can_merge)
                    begin
                        op_next  = bba_pkg::OP_MERGE;
                        tgt_next = baddr_reg ^ bsz[bba_pkg::ADDR_W-1:0];
                    end
                    else
                    begin
                        op_next  = bba_pkg::OP_SET;
                        tgt_next = baddr_reg;
                    end
                end
            end
            bba_pkg::S_SCAN:
            begin
                // one word read per cycle, checked in the next cycle
                ram_re         = scan_issue && !hit;
                ram_raddr      = scan_addr_reg[bba_pkg::WA_W-1:0];
                pend_next      = scan_issue && !hit;
                pend_addr_next = scan_addr_reg[bba_pkg::WA_W-1:0];
                scan_addr_next = scan_addr_reg + (bba_pkg::WA_W+1)'(1);
                if (hit)
                begin
                    op_next   = bba_pkg::OP_ALLOC_CLR;
                    addr_next = hit_addr;
                    tgt_next  = hit_addr;
                end
            end
            bba_pkg::S_RD:
            begin
                ram_re = 1'b1;
            end
            bba_pkg::S_MOD:
            begin
                ram_we              = 1'b1;
                wvalid_next[node_word] = 1'b1;
                case (op_reg)
                    bba_pkg::OP_ALLOC_CLR,
                    bba_pkg::OP_SPLIT_SET:
                    begin
                        if (op_reg == bba_pkg::OP_ALLOC_CLR)
                        begin
                            ram_wdata[node_bit] = 1'b0;
                            if (cur_bit)
                            begin
                                cnt_next[ord_reg] = cnt_reg[ord_reg] - bba_pkg::CNT_W'(1);
                            end
                        end
                        else
                        begin
                            ram_wdata[node_bit] = 1'b1;
                            if (!cur_bit)
                            begin
                                cnt_next[ord_reg] = cnt_reg[ord_reg] + bba_pkg::CNT_W'(1);
                            end
                        end
                        if (ord_reg > k_reg)
                        begin
                            // upper half of the split goes free
                            op_next  = bba_pkg::OP_SPLIT_SET;
                            ord_next = ord_reg - bba_pkg::ORD_W'(1);
                            tgt_next = addr_reg + ord_sz_dn;
                        end
                        else
                        begin
                            res_stat_next  = bba_pkg::STAT_OK;
                            res_grant_next = addr_reg;
                        end
                    end
                    bba_pkg::OP_MERGE:
                    begin
                        if (cur_bit)
                        begin
                            // buddy free: take it and move one order up
                            ram_wdata[node_bit] = 1'b0;
                            cnt_next[ord_reg]   = cnt_reg[ord_reg] - bba_pkg::CNT_W'(1);
                            addr_next           = merged;
                            ord_next            = ord_up[bba_pkg::ORD_W-1:0];
                            if ((ord_up + (bba_pkg::ORD_W+1)'(1))
                                < (bba_pkg::ORD_W+1)'(bba_pkg::NUM_ORDERS))
                            begin
                                tgt_next = merged ^ ord_sz_up;
                            end
                            else
                            begin
                                op_next  = bba_pkg::OP_SET;
                                tgt_next = merged;
                            end
                        end
                        else
                        begin
                            op_next  = bba_pkg::OP_SET;
                            tgt_next = addr_reg;
                        end
                    end
                    default:
                    begin
                        ram_wdata[node_bit] = 1'b1;
                        if (!cur_bit)
                        begin
                            cnt_next[ord_reg] = cnt_reg[ord_reg] + bba_pkg::CNT_W'(1);
                        end
                        res_stat_next  = bba_pkg::STAT_OK;
                        res_grant_next = '0;
                    end
                endcase
            end
            bba_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_stat_reg;
                    grant_next     = res_grant_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_ready       = (state_reg == bba_pkg::S_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign granted_address = grant_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            wvalid_reg    <= '0;
            for (int i = 0; i < bba_pkg::NUM_ORDERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            wvalid_reg    <= wvalid_next;
            if (ram_re)
            begin
                rd_vld_reg <= wvalid_reg[ram_raddr];
            end
            for (int i = 0; i < bba_pkg::NUM_ORDERS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg   <= command;
            size_reg  <= size_bytes;
            baddr_reg <= block_address;
        end
        op_reg        <= op_next;
        k_reg         <= k_next;
        ord_reg       <= ord_next;
        addr_reg      <= addr_next;
        tgt_reg       <= tgt_next;
        scan_addr_reg <= scan_addr_next;
        scan_last_reg <= scan_last_next;
        pend_addr_reg <= pend_addr_next;
        scan_base_reg <= scan_base_next;
        scan_mask_reg <= scan_mask_next;
        res_stat_reg  <= res_stat_next;
        res_grant_reg <= res_grant_next;
        status_reg    <= status_next;
        grant_reg     <= grant_next;
    end

endmodule

// ----- hw/rtl/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic [bba_pkg::CMD_W-1:0]  command,
    input logic [bba_pkg::SIZE_W-1:0] size_bytes,
    input logic [bba_pkg::ADDR_W-1:0] block_address,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [bba_pkg::STAT_W-1:0] status,
    input logic [bba_pkg::ADDR_W-1:0] granted_address
);

    // stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted_address))
        else $error("result item changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second item taken while busy");

    // a grant only comes with ok status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted_address != '0 |-> status == bba_pkg::STAT_OK)
        else $error("address given with error status");

    // grants are aligned to the minimum block
    a_grant_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> granted_address[bba_pkg::MIN_W-1:0] == '0)
        else $error("granted address misaligned");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// buddy allocator testbench
// Feeds allocate, free, donate and unused commands through the valid/ready command
// port, predicts each status and granted address with a bitmap model of the
// pool, and checks every response in order under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [bba_pkg::CMD_W-1:0]  cmd;
        logic [bba_pkg::SIZE_W-1:0] size;
        logic [bba_pkg::ADDR_W-1:0] addr;
    } alloc_item_t;

    typedef struct {
        logic [bba_pkg::STAT_W-1:0] stat;
        logic [bba_pkg::ADDR_W-1:0] grant;
    } alloc_rsp_t;

    typedef struct {
        int addr;
        int size;
    } live_block_t;

    localparam int N_RANDOM   = 400;
    localparam int CALM_AFTER = 360;
    localparam int WD_LIMIT   = 20000;

    logic                         clk;
    logic                         rst_n;
    logic                         cmd_valid;
    logic                         cmd_ready;
    logic [bba_pkg::CMD_W-1:0]    command;
    logic [bba_pkg::SIZE_W-1:0]   size_bytes;
    logic [bba_pkg::ADDR_W-1:0]   block_address;
    logic                         rsp_valid;
    logic                         rsp_ready;
    logic [bba_pkg::STAT_W-1:0]   status;
    logic [bba_pkg::ADDR_W-1:0]   granted_address;

    alloc_item_t  pending_items[$];
    alloc_rsp_t   expected_rsps[$];
    live_block_t  live_blocks[$];

    // model of the pool
    bit           pool_free[bba_pkg::MAP_BITS];
    int           pool_count[bba_pkg::NUM_ORDERS];

    int           errors;
    int           sent_count;
    int           send_gap;
    int           recv_gap;
    int           quiet_cycles;

    buddy_block_allocator_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .command         (command),
        .size_bytes      (size_bytes),
        .block_address   (block_address),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .status          (status),
        .granted_address (granted_address)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // least order holding the raised and rounded size
    function automatic int block_order(input int size);
        int r;
        int k;
        r = (size < bba_pkg::MIN_BLOCK_BYTES) ? bba_pkg::MIN_BLOCK_BYTES : size;
        r = (r + 7) & ~7;
        k = 0;
        while ((1 << k) < r)
        begin
            k++;
        end
        return k;
    endfunction

    function automatic int node_index(input int k, input int a);
        return (bba_pkg::POOL_BYTES >> k) + (a >> k);
    endfunction

    function automatic bit is_free(input int k, input int a);
        int n;
        n = node_index(k, a);
        if (n >= bba_pkg::MAP_BITS)
        begin
            return 1'b0;
        end
        return pool_free[n];
    endfunction

    task automatic mark_free(input int k, input int a);
        int n;
        n = node_index(k, a);
        if (n < bba_pkg::MAP_BITS && !pool_free[n])
        begin
            pool_free[n] = 1'b1;
            pool_count[k]++;
        end
    endtask

    task automatic mark_used(input int k, input int a);
        int n;
        n = node_index(k, a);
        if (n < bba_pkg::MAP_BITS && pool_free[n])
        begin
            pool_free[n] = 1'b0;
            pool_count[k]--;
        end
    endtask

    // predict one command and advance the pool model
    task automatic predict_alloc(input alloc_item_t it, output alloc_rsp_t rsp);
        int k;
        int j;
        int idx;
        int a;
        int bsz;
        int nblk;
        rsp.stat  = bba_pkg::STAT_OK;
        rsp.grant = '0;
        if (it.cmd != bba_pkg::CMD_NONE)
        begin
            k = block_order(int'(it.size));
            a = int'(it.addr);
            if (k >= bba_pkg::NUM_ORDERS)
            begin
                rsp.stat = bba_pkg::STAT_TOO_BIG;
            end
            else if (it.cmd == bba_pkg::CMD_ALLOC)
            begin
                j = k;
                while (j < bba_pkg::NUM_ORDERS && pool_count[j] == 0)
                begin
                    j++;
                end
                if (j >= bba_pkg::NUM_ORDERS)
                begin
                    rsp.stat = bba_pkg::STAT_NO_FREE;
                end
                else
                begin
                    nblk = bba_pkg::POOL_BYTES >> j;
                    idx = 0;
                    while (idx < nblk && !is_free(j, idx << j))
                    begin
                        idx++;
                    end
                    if (idx >= nblk)
                    begin
                        rsp.stat = bba_pkg::STAT_NO_FREE;
                    end
                    else
                    begin
                        a = idx << j;
                        mark_used(j, a);
                        while (j > k)
                        begin
                            j--;
                            mark_free(j, a + (1 << j));
                        end
                        rsp.grant = bba_pkg::ADDR_W'(a);
                    end
                end
            end
            else
            begin
                bsz = 1 << k;
                if ((a & (bsz - 1)) != 0 || a + bsz > bba_pkg::POOL_BYTES)
                begin
                    rsp.stat = bba_pkg::STAT_MISALIGN;
                end
                else if (it.cmd == bba_pkg::CMD_DONATE)
                begin
                    mark_free(k, a);
                end
                else
                begin
                    // merge with free buddies, keeping the lower address
                    while (k + 1 < bba_pkg::NUM_ORDERS && is_free(k, a ^ (1 << k)))
                    begin
                        mark_used(k, a ^ (1 << k));
                        a = a & ~(1 << k);
                        k++;
                    end
                    mark_free(k, a);
                end
            end
        end
    endtask

    // queue one item with its expected response
    task automatic push_item(input logic [bba_pkg::CMD_W-1:0] c, input int s, input int a);
        alloc_item_t it;
        alloc_rsp_t  rsp;
        live_block_t lb;
        it.cmd  = c;
        it.size = bba_pkg::SIZE_W'(s);
        it.addr = bba_pkg::ADDR_W'(a);
        predict_alloc(it, rsp);
        if (c == bba_pkg::CMD_ALLOC && rsp.stat == bba_pkg::STAT_OK)
        begin
            lb.addr = int'(rsp.grant);
            lb.size = int'(it.size);
            live_blocks.push_back(lb);
        end
        pending_items.push_back(it);
        expected_rsps.push_back(rsp);
    endtask

    // command driver with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid     <= 1'b0;
            command       <= bba_pkg::CMD_NONE;
            size_bytes    <= '0;
            block_address <= '0;
            send_gap      <= 0;
            sent_count    <= 0;
        end
        else if (!cmd_valid || cmd_ready)
        begin
            if (cmd_valid)
            begin
                sent_count <= sent_count + 1;
            end
            if (send_gap > 0)
            begin
                cmd_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (pending_items.size() == 0)
            begin
                cmd_valid <= 1'b0;
            end
            else if (sent_count < CALM_AFTER && $urandom_range(0, 9) == 0)
            begin
                cmd_valid <= 1'b0;
                send_gap  <= $urandom_range(0, 14);
            end
            else
            begin
                cmd_valid     <= 1'b1;
                command       <= pending_items[0].cmd;
                size_bytes    <= pending_items[0].size;
                block_address <= pending_items[0].addr;
                void'(pending_items.pop_front());
            end
        end
    end

    // response monitor with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_gap  <= 0;
            errors    <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response status %0d address %0d",
                             $realtime, status, granted_address);
                    errors <= errors + 1;
                end
                else
                begin
                    if (status !== expected_rsps[0].stat ||
                        granted_address !== expected_rsps[0].grant)
                    begin
                        $display("%0t: mismatch expected status %0d address %0d, got %0d %0d",
                                 $realtime, expected_rsps[0].stat, expected_rsps[0].grant,
                                 status, granted_address);
                        errors <= errors + 1;
                    end
                    void'(expected_rsps.pop_front());
                end
            end
            if (recv_gap > 0)
            begin
                rsp_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end
            else if (sent_count < CALM_AFTER && $urandom_range(0, 9) == 0)
            begin
                rsp_ready <= 1'b0;
                recv_gap  <= $urandom_range(0, 14);
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any item accepted
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WD_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and end of run
    initial
    begin
        int          r;
        int          k;
        int          s;
        int          a;
        int          p;
        live_block_t lb;
        rst_n        = 1'b0;
        // directed part
        push_item(bba_pkg::CMD_NONE, 16'hFFFF, 15'h7FFF);
        push_item(bba_pkg::CMD_ALLOC, 0, 0);
        push_item(bba_pkg::CMD_ALLOC, 16'hFFFF, 0);
        push_item(bba_pkg::CMD_FREE, 32769, 0);
        push_item(bba_pkg::CMD_DONATE, 40000, 0);
        push_item(bba_pkg::CMD_DONATE, 32768, 0);
        push_item(bba_pkg::CMD_ALLOC, 32768, 0);
        push_item(bba_pkg::CMD_FREE, 32768, 0);
        push_item(bba_pkg::CMD_ALLOC, 1, 0);
        push_item(bba_pkg::CMD_ALLOC, 17, 0);
        push_item(bba_pkg::CMD_ALLOC, 16384, 0);
        push_item(bba_pkg::CMD_FREE, 16, 8);
        push_item(bba_pkg::CMD_DONATE, 64, 15'h7FFF);
        push_item(bba_pkg::CMD_FREE, 16, 0);
        push_item(bba_pkg::CMD_FREE, 16, 0);
        push_item(bba_pkg::CMD_DONATE, 16, 16);
        push_item(bba_pkg::CMD_FREE, 24, 32);
        push_item(bba_pkg::CMD_FREE, 16384, 16384);
        push_item(bba_pkg::CMD_DONATE, 16, 15'h7FF0);
        push_item(bba_pkg::CMD_ALLOC, 9, 0);
        push_item(bba_pkg::CMD_NONE, 0, 0);
        live_blocks.delete();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // random part
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                // hold off until every response has come back
                while (pending_items.size() != 0 || expected_rsps.size() != 0 ||
                       cmd_valid)
                begin
                    @(posedge clk);
                end
            end
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                p = $urandom_range(0, 19);
                s = (p == 0) ? $urandom_range(0, 16'hFFFF) :
                    (p < 3) ? $urandom_range(0, 32768) : $urandom_range(0, 600);
                push_item(bba_pkg::CMD_ALLOC, s, $urandom_range(0, 15'h7FFF));
            end
            else if (r < 80 && live_blocks.size() != 0)
            begin
                p = $urandom_range(0, live_blocks.size() - 1);
                lb = live_blocks[p];
                live_blocks.delete(p);
                push_item(bba_pkg::CMD_FREE, lb.size, lb.addr);
            end
            else if (r < 92)
            begin
                k = $urandom_range(3, bba_pkg::NUM_ORDERS - 1);
                a = ($urandom_range(0, 15'h7FFF) >> k) << k;
                s = (1 << k) - $urandom_range(0, 7);
                push_item(bba_pkg::CMD_DONATE, s, a);
            end
            else
            begin
                push_item(bba_pkg::CMD_ALLOC + bba_pkg::CMD_W'($urandom_range(1, 3)),
                          $urandom_range(0, 16'hFFFF), $urandom_range(0, 15'h7FFF));
            end
            // keep the feed shallow so pauses land between items
            while (pending_items.size() > 4)
            begin
                @(posedge clk);
            end
        end
        while (pending_items.size() != 0 || expected_rsps.size() != 0 || cmd_valid)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
